FILE: rtl/plcp_pkg.sv
// Shared types, constants and segment tables for the count/PM2.5 converter.
`timescale 1ns / 1ps

package plcp_pkg;

    // Field and table widths
    localparam int VAL_W     = 20;
    localparam int TAB_W     = 13;
    localparam int PROD_W    = VAL_W + TAB_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int BASE_W    = 17;
    localparam int TDATA_W   = 24;

    // Segment table
    localparam int TABLE_LEN    = 21;
    localparam int SEG_IDX_W    = $clog2(TABLE_LEN);
    localparam int SEGMENTS_DEF = 21;

    // Limits
    localparam logic [VAL_W-1:0] RESULT_MAX   = '1;
    localparam logic [VAL_W-1:0] MAX_CONC_RST = 20'd99999;

    // Input queue depth (power of two)
    localparam int Q_DEPTH = 2;

    // Request kinds
    localparam logic REQ_FWD = 1'b0;
    localparam logic REQ_INV = 1'b1;

    typedef logic [SEG_IDX_W-1:0] seg_idx_t;

    // Segment widths along the count axis
    localparam logic [TAB_W-1:0] SEG_DX [TABLE_LEN] = '{
        13'd1900, 13'd400,  13'd700,  13'd600,  13'd900,  13'd1800, 13'd1200,
        13'd2500, 13'd2300, 13'd4400, 13'd2300, 13'd2800, 13'd4400, 13'd4800,
        13'd4200, 13'd3600, 13'd6200, 13'd6800, 13'd6200, 13'd3000, 13'd3200
    };

    // Segment heights along the concentration axis
    localparam logic [TAB_W-1:0] SEG_DY [TABLE_LEN] = '{
        13'd7125, 13'd1258, 13'd2551, 13'd2187, 13'd2378, 13'd4000, 13'd2500,
        13'd5000, 13'd4000, 13'd6500, 13'd2500, 13'd1500, 13'd2254, 13'd1746,
        13'd2100, 13'd2064, 13'd2986, 13'd2776, 13'd3574, 13'd3000, 13'd4500
    };

    // One queued request
    typedef struct packed {
        logic             inv;
        logic [VAL_W-1:0] value;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

FILE: rtl/plcp_front.sv
// Front end: accepts input items, decodes the request kind and queues them.
`timescale 1ns / 1ps

module plcp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plcp_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    output plcp_pkg::q_head_t             head,
    input  logic                          pop
);

    localparam int QPW = $clog2(plcp_pkg::Q_DEPTH);
    localparam int QCW = $clog2(plcp_pkg::Q_DEPTH + 1);

    plcp_pkg::item_t  mem_reg [plcp_pkg::Q_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             push;
    plcp_pkg::item_t  in_item;

    // Classify the incoming item
    always_comb
    begin
        in_item.inv   = (s_tuser == plcp_pkg::REQ_INV);
        in_item.value = s_tdata[plcp_pkg::VAL_W-1:0];
    end

    assign s_tready = (count_reg != QCW'(plcp_pkg::Q_DEPTH));
    assign push     = s_tvalid && s_tready;

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(plcp_pkg::Q_DEPTH))
        else $error("queue count overflow");
`endif

endmodule

FILE: rtl/plcp_back.sv
// Back end: segment walk, remainder scaling, serial divide, base add, saturation, output.
`timescale 1ns / 1ps

module plcp_back
#(
    parameter int SEGMENTS = plcp_pkg::SEGMENTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  plcp_pkg::q_head_t             head,
    output logic                          pop,
    input  logic [plcp_pkg::VAL_W-1:0]    max_conc,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plcp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);

    localparam int USED = (SEGMENTS > plcp_pkg::TABLE_LEN) ? plcp_pkg::TABLE_LEN : SEGMENTS;
    localparam int IW   = $clog2(USED);
    localparam int BCW  = $clog2(plcp_pkg::PROD_W);
    localparam int VW   = plcp_pkg::VAL_W;
    localparam int TW   = plcp_pkg::TAB_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [IW-1:0] LAST_IDX = IW'(USED - 1);

    logic [2:0]                    state_reg, state_next;
    logic                          inv_reg, inv_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [VW-1:0]                 rem_reg, rem_next;
    logic [plcp_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [plcp_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [TW-1:0]                 dvsr_reg, dvsr_next;
    logic [TW-1:0]                 prem_reg, prem_next;
    logic [BCW-1:0]                bcnt_reg, bcnt_next;
    logic [plcp_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic                          out_valid_reg, out_valid_next;
    logic [VW-1:0]                 res_reg, res_next;
    logic                          sat_reg, sat_next;

    plcp_pkg::seg_idx_t            tab_idx;
    logic [TW-1:0]                 run;
    logic [TW-1:0]                 rise;
    logic [TW:0]                   trial;
    logic                          qbit;
    logic [VW-1:0]                 limit;
    logic                          load_out;

    // Table lookup: run along the input axis, rise along the output axis
    assign tab_idx = plcp_pkg::seg_idx_t'(idx_reg);
    assign run     = inv_reg ? plcp_pkg::SEG_DY[tab_idx] : plcp_pkg::SEG_DX[tab_idx];
    assign rise    = inv_reg ? plcp_pkg::SEG_DX[tab_idx] : plcp_pkg::SEG_DY[tab_idx];

    // Restoring divide step
    assign trial = {prem_reg, prod_reg[plcp_pkg::PROD_W-1]};
    assign qbit  = (trial >= {1'b0, dvsr_reg});

    assign limit    = inv_reg ? plcp_pkg::RESULT_MAX : max_conc;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        inv_next   = inv_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        prod_next  = prod_reg;
        dvsr_next  = dvsr_reg;
        prem_next  = prem_reg;
        bcnt_next  = bcnt_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    inv_next   = head.item.inv;
                    rem_next   = head.item.value;
                    idx_next   = '0;
                    base_next  = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == LAST_IDX || rem_reg < VW'(run))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    rem_next  = rem_reg - VW'(run);
                    base_next = base_reg + plcp_pkg::BASE_W'(rise);
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next  = plcp_pkg::PROD_W'(rem_reg) * plcp_pkg::PROD_W'(rise);
                dvsr_next  = run;
                prem_next  = '0;
                bcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                prem_next = qbit ? TW'(trial - {1'b0, dvsr_reg}) : trial[TW-1:0];
                prod_next = {prod_reg[plcp_pkg::PROD_W-2:0], qbit};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == BCW'(plcp_pkg::PROD_W - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                sum_next   = plcp_pkg::SUM_W'(base_reg) + plcp_pkg::SUM_W'(prod_next);
                sum_next   = plcp_pkg::SUM_W'(base_reg) + plcp_pkg::SUM_W'(prod_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    if (sum_reg > plcp_pkg::SUM_W'(limit))
                    begin
                        res_next = limit;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        res_next = sum_reg[VW-1:0];
                        sat_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inv_reg  <= inv_next;
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        prod_reg <= prod_next;
        dvsr_reg <= dvsr_next;
        prem_reg <= prem_next;
        bcnt_reg <= bcnt_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = plcp_pkg::TDATA_W'(res_reg);
    assign m_tuser  = sat_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg <= LAST_IDX)
        else $error("segment index past last used segment");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (res_reg == plcp_pkg::RESULT_MAX || res_reg == max_conc))
        else $error("saturated result not at a limit");

    a_prem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> prem_reg < dvsr_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: rtl/piecewise_linear_count_to_pm.sv
// Top level: count/PM2.5 piecewise-linear converter with saturation register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tdata[19:0] value, tuser req_type
//  m_      | out       | m_tvalid/m_tready  | tdata[19:0] result, tuser saturated
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data[19:0] max_concentration
//
// An item walks k segments from the queue head, k = 1..SEGMENTS (at most 21), one segment per
// cycle; its remainder is then scaled and run through the 33-step serial divider.
// Reset (rst_n, async low) empties the queue and output slot; max_concentration -> 99999.
// Input queue holds two items; a finished result waits in the output register while the
// next item is worked on, and the back end holds its last step only while that register
// is still full.
`timescale 1ns / 1ps

module piecewise_linear_count_to_pm
#(
    parameter int SEGMENTS = plcp_pkg::SEGMENTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: value[19:0]; s_tuser: req_type
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plcp_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    // m_tdata: result[19:0]; m_tuser: saturated
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plcp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    // cfg_data: max_concentration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plcp_pkg::VAL_W-1:0]    cfg_data
);

    plcp_pkg::q_head_t              head;
    logic                           pop;
    logic [plcp_pkg::VAL_W-1:0]     max_conc_reg, max_conc_next;

    // Saturation limit register
    assign cfg_ready     = 1'b1;
    assign max_conc_next = (cfg_valid && cfg_ready) ? cfg_data : max_conc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_conc_reg <= plcp_pkg::MAX_CONC_RST;
        end
        else
        begin
            max_conc_reg <= max_conc_next;
        end
    end

    plcp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    plcp_back
    #(
        .SEGMENTS (SEGMENTS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .max_conc (max_conc_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
